@@ design/hysteresis_thermostat_with_failsafe_assert.svh @@
// Assertion macros for the thermostat block.
`ifndef HYSTERESIS_THERMOSTAT_WITH_FAILSAFE_ASSERT_SVH
`define HYSTERESIS_THERMOSTAT_WITH_FAILSAFE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thermostat check failed");

// Next-cycle implication, checked outside reset.
`define HTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thermostat check failed");

`endif

@@ design/hts_pkg.sv @@
`default_nettype none

package hts_pkg;

  // Default reading width
  localparam int TEMP_BITS_DEF = 12;

  // Configuration port
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET  = 3'd0,
    REG_BAND    = 3'd1,
    REG_MAX     = 3'd2,
    REG_MISSING = 3'd3,
    REG_SLOW    = 3'd4,
    REG_FAST    = 3'd5,
    REG_RAPID   = 3'd6
  } cfg_idx_e;

  // Register reset values (24.0 C, 0.25 C, 28.0 C in sixteenths)
  localparam int          TARGET_RESET  = 384;
  localparam int          MAX_RESET     = 448;
  localparam logic [7:0]  BAND_RESET    = 8'd4;
  localparam logic [7:0]  MISSING_RESET = 8'd5;
  localparam logic [15:0] SLOW_RESET    = 16'd10000;
  localparam logic [15:0] FAST_RESET    = 16'd1000;
  localparam logic [15:0] RAPID_RESET   = 16'd50;

  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

  // Event codes
  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_READING = 2'd1,
    ACT_MISSING = 2'd2
  } action_e;

  // LED blink modes
  typedef enum logic [1:0] {
    MODE_COOL  = 2'd0,
    MODE_HEAT  = 2'd1,
    MODE_PANIC = 2'd2
  } mode_e;

  // Width-fixed configuration fields
  typedef struct packed {
    logic [7:0]  band;
    logic [7:0]  missing_limit;
    logic [15:0] slow_half;
    logic [15:0] fast_half;
    logic [15:0] rapid_half;
  } cfg_t;

  // Controller state
  typedef struct packed {
    logic        heat_phase;
    logic        relay_state;
    logic        panic_latch;
    logic [7:0]  missing_count;
    mode_e       blink_mode;
    logic        blink_level;
    logic [15:0] blink_elapsed;
  } state_t;

endpackage

`default_nettype wire

@@ design/hts_in_if.sv @@
`default_nettype none

interface hts_in_if #(
  parameter int TempBits = hts_pkg::TEMP_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic signed [TempBits-1:0] temperature;

  modport source (output valid, output action, output temperature, input ready);
  modport sink   (input valid, input action, input temperature, output ready);
endinterface

`default_nettype wire

@@ design/hts_out_if.sv @@
`default_nettype none

interface hts_out_if;
  logic       valid;
  logic       ready;
  logic       relay_on;
  logic       led_on;
  logic       panic;
  logic       heating;
  logic [1:0] led_mode;

  modport source (output valid, output relay_on, output led_on, output panic,
                  output heating, output led_mode, input ready);
  modport sink   (input valid, input relay_on, input led_on, input panic,
                  input heating, input led_mode, output ready);
endinterface

`default_nettype wire

@@ design/hysteresis_thermostat_with_failsafe.sv @@
// Hysteresis thermostat with fail-safe latch and status LED blinker.
//
// in_i carries one event per transfer: action (tick, reading, sensor
// missing) and a signed temperature in sixteenths of a degree. out_o carries
// one result per event: relay, LED level, panic, heating phase and LED mode,
// all as they stand after that event.
// The configuration port writes one register per cycle with cfg_we_i high:
// target, band, max, missing limit, then the three LED half periods.
// An event's result is registered at the edge that takes the event and shows
// on out_o from then on. Throughput is one event per cycle while results
// are taken; the combinational update loads the state and result registers.
// in_i.ready stays high while the result register is empty or being taken,
// so a stalled receiver holds the result and stops the input at once until
// that result is taken; no event is lost.
// Reset clears the controller to cooling, relay off, LED off, no panic,
// and loads every configuration register with its default.
// Panic is kept until reset; ticks still blink the LED during panic.

`default_nettype none

module hysteresis_thermostat_with_failsafe #(
  parameter int TEMP_BITS = hts_pkg::TEMP_BITS_DEF,
  parameter int CFG_W     = (TEMP_BITS > 16) ? TEMP_BITS : 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  hts_in_if.sink                             in_i,
  hts_out_if.source                          out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [hts_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]              cfg_data_i
);

  logic signed [TEMP_BITS-1:0] target, max_lim, temp_in;
  hts_pkg::cfg_t               cfg;
  hts_pkg::state_t             state_q, state_d;
  logic                        out_valid_q, in_xfer;

  logic relay_q, led_q, panic_q, heating_q;
  logic [1:0] mode_q;

  hts_cfg #(
    .TempBits (TEMP_BITS),
    .CfgW     (CFG_W)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (cfg_we_i),
    .idx_i    (cfg_idx_i),
    .data_i   (cfg_data_i),
    .target_o (target),
    .max_o    (max_lim),
    .cfg_o    (cfg)
  );

  assign temp_in = in_i.temperature;

  hts_core #(
    .TempBits (TEMP_BITS)
  ) u_core (
    .state_i  (state_q),
    .action_i (in_i.action),
    .temp_i   (temp_in),
    .target_i (target),
    .max_i    (max_lim),
    .cfg_i    (cfg),
    .state_o  (state_d)
  );

  // Accept while the result register is empty or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  // Advance the controller state on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.heat_phase    <= 1'b0;
      state_q.relay_state   <= 1'b0;
      state_q.panic_latch   <= 1'b0;
      state_q.missing_count <= '0;
      state_q.blink_mode    <= hts_pkg::MODE_COOL;
      state_q.blink_level   <= 1'b0;
      state_q.blink_elapsed <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // Hold the result until the output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      relay_q   <= state_d.relay_state;
      led_q     <= state_d.blink_level;
      panic_q   <= state_d.panic_latch;
      heating_q <= state_d.heat_phase;
      mode_q    <= state_d.blink_mode;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.relay_on = relay_q;
  assign out_o.led_on   = led_q;
  assign out_o.panic    = panic_q;
  assign out_o.heating  = heating_q;
  assign out_o.led_mode = mode_q;

`include "hysteresis_thermostat_with_failsafe_assert.svh"

  // Panic always holds the heater off
  `HTS_ASSERT_NOW(a_panic_relay_off, clk_i, rst_ni, out_o.valid && out_o.panic, !out_o.relay_on && !out_o.heating)

  // Relay follows the heating phase
  `HTS_ASSERT_NOW(a_relay_phase, clk_i, rst_ni, 1'b1, state_q.relay_state == state_q.heat_phase)

  // Panic latch is kept until reset
  `HTS_ASSERT_NEXT(a_panic_sticky, clk_i, rst_ni, state_q.panic_latch, state_q.panic_latch)

  // Every input transfer leaves a pending result
  `HTS_ASSERT_NEXT(a_result_after_xfer, clk_i, rst_ni, in_xfer, out_valid_q)

endmodule

`default_nettype wire

@@ design/hts_cfg.sv @@
`default_nettype none

module hts_cfg #(
  parameter int TempBits = hts_pkg::TEMP_BITS_DEF,
  parameter int CfgW     = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          we_i,
  input  wire logic [hts_pkg::CFG_IDX_W-1:0] idx_i,
  input  wire logic [CfgW-1:0]               data_i,
  output logic signed [TempBits-1:0]         target_o,
  output logic signed [TempBits-1:0]         max_o,
  output hts_pkg::cfg_t                      cfg_o
);

  logic signed [TempBits-1:0] target_q, max_q;
  hts_pkg::cfg_t              cfg_q;

  // Write one register per enabled cycle; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q            <= TempBits'(hts_pkg::TARGET_RESET);
      max_q               <= TempBits'(hts_pkg::MAX_RESET);
      cfg_q.band          <= hts_pkg::BAND_RESET;
      cfg_q.missing_limit <= hts_pkg::MISSING_RESET;
      cfg_q.slow_half     <= hts_pkg::SLOW_RESET;
      cfg_q.fast_half     <= hts_pkg::FAST_RESET;
      cfg_q.rapid_half    <= hts_pkg::RAPID_RESET;
    end else if (we_i) begin
      case (hts_pkg::cfg_idx_e'(idx_i))
        hts_pkg::REG_TARGET:  target_q            <= data_i[TempBits-1:0];
        hts_pkg::REG_BAND:    cfg_q.band          <= data_i[7:0];
        hts_pkg::REG_MAX:     max_q               <= data_i[TempBits-1:0];
        hts_pkg::REG_MISSING: cfg_q.missing_limit <= data_i[7:0];
        hts_pkg::REG_SLOW:    cfg_q.slow_half     <= data_i[15:0];
        hts_pkg::REG_FAST:    cfg_q.fast_half     <= data_i[15:0];
        hts_pkg::REG_RAPID:   cfg_q.rapid_half    <= data_i[15:0];
        default: ;
      endcase
    end
  end

  assign target_o = target_q;
  assign max_o    = max_q;
  assign cfg_o    = cfg_q;

endmodule

`default_nettype wire

@@ design/hts_core.sv @@
`default_nettype none

module hts_core #(
  parameter int TempBits = hts_pkg::TEMP_BITS_DEF
) (
  input  wire hts_pkg::state_t              state_i,
  input  wire logic [1:0]                   action_i,
  input  wire logic signed [TempBits-1:0]   temp_i,
  input  wire logic signed [TempBits-1:0]   target_i,
  input  wire logic signed [TempBits-1:0]   max_i,
  input  wire hts_pkg::cfg_t                cfg_i,
  output hts_pkg::state_t                   state_o
);

  localparam int SumW = TempBits + 2;

  logic signed [SumW-1:0] temp_ext, target_ext, band_ext, hi_lim, lo_lim;
  logic [15:0]            half_period, elapsed_inc;

  // Restart the LED on when the blink mode changes
  function automatic hts_pkg::state_t set_mode(hts_pkg::state_t s, hts_pkg::mode_e m);
    hts_pkg::state_t r;
    r = s;
    if (m != s.blink_mode) begin
      r.blink_mode    = m;
      r.blink_level   = 1'b1;
      r.blink_elapsed = '0;
    end
    return r;
  endfunction

  // Latch panic: relay off, cooling phase, panic blink
  function automatic hts_pkg::state_t enter_panic(hts_pkg::state_t s);
    hts_pkg::state_t r;
    r             = s;
    r.panic_latch = 1'b1;
    r.relay_state = 1'b0;
    r.heat_phase  = 1'b0;
    return set_mode(r, hts_pkg::MODE_PANIC);
  endfunction

  // Hysteresis thresholds
  assign temp_ext   = SumW'(temp_i);
  assign target_ext = SumW'(target_i);
  assign band_ext   = $signed({{(SumW-8){1'b0}}, cfg_i.band});
  assign hi_lim     = target_ext + band_ext;
  assign lo_lim     = target_ext - band_ext;

  // Half period of the current blink mode
  always_comb begin
    case (state_i.blink_mode)
      hts_pkg::MODE_HEAT:  half_period = cfg_i.fast_half;
      hts_pkg::MODE_PANIC: half_period = cfg_i.rapid_half;
      default:             half_period = cfg_i.slow_half;
    endcase
  end

  // Saturating tick count
  assign elapsed_inc = (state_i.blink_elapsed != hts_pkg::ELAPSED_MAX) ?
                       state_i.blink_elapsed + 16'd1 : state_i.blink_elapsed;

  // Apply one event to the state
  always_comb begin
    state_o = state_i;
    case (hts_pkg::action_e'(action_i))
      hts_pkg::ACT_TICK: begin
        if (elapsed_inc >= half_period) begin
          state_o.blink_level   = ~state_i.blink_level;
          state_o.blink_elapsed = '0;
        end else begin
          state_o.blink_elapsed = elapsed_inc;
        end
      end
      hts_pkg::ACT_READING: begin
        if (!state_i.panic_latch) begin
          state_o.missing_count = '0;
          if (temp_i > max_i) begin
            state_o = enter_panic(state_o);
          end else if (state_i.heat_phase && (temp_ext >= hi_lim)) begin
            state_o.relay_state = 1'b0;
            state_o.heat_phase  = 1'b0;
            state_o             = set_mode(state_o, hts_pkg::MODE_COOL);
          end else if (!state_i.heat_phase && (temp_ext <= lo_lim)) begin
            state_o.relay_state = 1'b1;
            state_o.heat_phase  = 1'b1;
            state_o             = set_mode(state_o, hts_pkg::MODE_HEAT);
          end
        end
      end
      hts_pkg::ACT_MISSING: begin
        if (!state_i.panic_latch) begin
          if (state_i.missing_count >= cfg_i.missing_limit) begin
            state_o = enter_panic(state_o);
          end else begin
            state_o.missing_count = state_i.missing_count + 8'd1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
